### sv/mas_pkg.sv
`default_nettype none

package mas_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 3;
    localparam int unsigned DIM_W  = 4;
    localparam int unsigned CIDX_W = 4;

    typedef enum logic [2:0] {
        OP_LOAD_A  = 3'd0,
        OP_LOAD_B  = 3'd1,
        OP_SUM     = 3'd2,
        OP_DIFF    = 3'd3,
        OP_PRODUCT = 3'd4
    } op_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_ROWS_A = 4'd0,
        REG_COLS_A = 4'd1,
        REG_ROWS_B = 4'd2,
        REG_COLS_B = 4'd3
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic             valid;
        logic             first_k;
        logic             last_k;
        logic             last_elem;
        logic             err;
        op_t              op;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } tok_t;

endpackage

`default_nettype wire

### sv/mas_cmd_if.sv
`default_nettype none

interface mas_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       operation;
    logic [mas_pkg::POS_W-1:0]        row;
    logic [mas_pkg::POS_W-1:0]        col;
    logic signed [mas_pkg::DATA_W-1:0] value;

    modport source (output valid, output operation, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input operation, input row, input col, input value,
                    output ready);
endinterface

`default_nettype wire

### sv/mas_rsp_if.sv
`default_nettype none

interface mas_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [mas_pkg::POS_W-1:0]         out_row;
    logic [mas_pkg::POS_W-1:0]         out_col;
    logic signed [mas_pkg::DATA_W-1:0] result;
    logic                              status;
    logic                              last;

    modport source (output valid, output out_row, output out_col, output result,
                    output status, output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input result,
                    input status, input last, output ready);
endinterface

`default_nettype wire

### sv/mas_cfg_if.sv
`default_nettype none

interface mas_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mas_pkg::CIDX_W-1:0]  index;
    logic [mas_pkg::DIM_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/mas_store.sv
`default_nettype none

module mas_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [mas_pkg::DATA_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr,
    output logic      [mas_pkg::DATA_W-1:0] rdata
);

    logic [mas_pkg::DATA_W-1:0] mem [DEPTH];
    logic [mas_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/mas_seq.sv
`default_nettype none

module mas_seq #(
    parameter int MAX_DIM = 8,
    parameter int IW      = 3,
    parameter int DW      = 4,
    parameter int AW      = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    mas_cmd_if.sink                         cmd,
    mas_cfg_if.sink                         cfg,
    input  wire logic                       stall,
    output mas_pkg::tok_t                   tok,
    output logic                            we_a,
    output logic                            we_b,
    output logic [AW-1:0]                   waddr,
    output logic [mas_pkg::DATA_W-1:0]      wdata,
    output logic                            re,
    output logic [AW-1:0]                   raddr_a,
    output logic [AW-1:0]                   raddr_b
);

    mas_pkg::state_t state_reg, state_next;

    logic [mas_pkg::DIM_W-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;

    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DW-1:0] nr_reg, nr_next, nc_reg, nc_next, nk_reg, nk_next;
    mas_pkg::op_t  op_reg, op_next;
    logic          err_reg, err_next;

    logic [DW-1:0] ra, ca, rb, cb;
    logic          accept, advance, load_ok, is_emit, shape_bad;
    logic          k_end, j_end, i_end;
    mas_pkg::op_t  cmd_op;

    function automatic logic [DW-1:0] dim_eff(input logic [mas_pkg::DIM_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)
            r = DW'(1);
        else if (int'(v) > MAX_DIM)
            r = DW'(MAX_DIM);
        else
            r = DW'(v);
        return r;
    endfunction

    assign ra = dim_eff(rows_a_reg);
    assign ca = dim_eff(cols_a_reg);
    assign rb = dim_eff(rows_b_reg);
    assign cb = dim_eff(cols_b_reg);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= mas_pkg::DIM_RESET;
            cols_a_reg <= mas_pkg::DIM_RESET;
            rows_b_reg <= mas_pkg::DIM_RESET;
            cols_b_reg <= mas_pkg::DIM_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mas_pkg::REG_ROWS_A: rows_a_reg <= cfg.data;
                mas_pkg::REG_COLS_A: cols_a_reg <= cfg.data;
                mas_pkg::REG_ROWS_B: rows_b_reg <= cfg.data;
                mas_pkg::REG_COLS_B: cols_b_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cmd_op    = mas_pkg::op_t'(cmd.operation);
    assign accept    = cmd.valid && cmd.ready;
    assign load_ok   = (int'(cmd.row) < MAX_DIM) && (int'(cmd.col) < MAX_DIM);
    assign is_emit   = (cmd_op == mas_pkg::OP_SUM) || (cmd_op == mas_pkg::OP_DIFF) ||
                       (cmd_op == mas_pkg::OP_PRODUCT);
    assign shape_bad = (cmd_op == mas_pkg::OP_PRODUCT) ? (ca != rb)
                                                        : ((ra != rb) || (ca != cb));

    assign advance = (state_reg == mas_pkg::ST_RUN) && !stall;
    assign k_end   = err_reg || ((DW'(k_reg) + DW'(1)) == nk_reg);
    assign j_end   = err_reg || ((DW'(j_reg) + DW'(1)) == nc_reg);
    assign i_end   = err_reg || ((DW'(i_reg) + DW'(1)) == nr_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mas_pkg::ST_IDLE:
            begin
                if (accept && is_emit)
                    state_next = mas_pkg::ST_RUN;
            end
            mas_pkg::ST_RUN:
            begin
                if (advance && k_end && j_end && i_end)
                    state_next = mas_pkg::ST_IDLE;
            end
            default: state_next = mas_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.ready = (state_reg == mas_pkg::ST_IDLE);
        we_a      = accept && load_ok && (cmd_op == mas_pkg::OP_LOAD_A);
        we_b      = accept && load_ok && (cmd_op == mas_pkg::OP_LOAD_B);
        waddr     = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
        wdata     = cmd.value;
        re        = advance && !err_reg;
        if (op_reg == mas_pkg::OP_PRODUCT)
        begin
            raddr_a = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
            raddr_b = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));
        end
        else
        begin
            raddr_a = AW'(int'(i_reg) * MAX_DIM + int'(j_reg));
            raddr_b = raddr_a;
        end
        tok.valid     = advance;
        tok.first_k   = (k_reg == '0);
        tok.last_k    = k_end;
        tok.last_elem = k_end && j_end && i_end;
        tok.err       = err_reg;
        tok.op        = op_reg;
        tok.row       = err_reg ? '0 : mas_pkg::POS_W'(i_reg);
        tok.col       = err_reg ? '0 : mas_pkg::POS_W'(j_reg);
    end

    // counters
    always_comb
    begin
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        nr_next  = nr_reg;
        nc_next  = nc_reg;
        nk_next  = nk_reg;
        op_next  = op_reg;
        err_next = err_reg;
        if (accept && is_emit)
        begin
            i_next   = '0;
            j_next   = '0;
            k_next   = '0;
            op_next  = cmd_op;
            err_next = shape_bad;
            nr_next  = ra;
            nc_next  = (cmd_op == mas_pkg::OP_PRODUCT) ? cb : ca;
            nk_next  = (cmd_op == mas_pkg::OP_PRODUCT) ? ca : DW'(1);
        end
        else if (advance)
        begin
            if (!k_end)
                k_next = k_reg + IW'(1);
            else
            begin
                k_next = '0;
                if (!j_end)
                    j_next = j_reg + IW'(1);
                else
                begin
                    j_next = '0;
                    i_next = i_reg + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mas_pkg::ST_IDLE;
            err_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nr_reg <= nr_next;
        nc_reg <= nc_next;
        nk_reg <= nk_next;
        op_reg <= op_next;
    end

endmodule

`default_nettype wire

### sv/mas_datapath.sv
`default_nettype none

module mas_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mas_pkg::tok_t              tok,
    input  wire logic [mas_pkg::DATA_W-1:0] a_data,
    input  wire logic [mas_pkg::DATA_W-1:0] b_data,
    output logic                            stall,
    mas_rsp_if.source                       rsp
);

    mas_pkg::tok_t s1_reg, s2_reg;
    logic [mas_pkg::DATA_W-1:0] prod_reg, acc_reg, sum, prod_next;
    logic [mas_pkg::DATA_W-1:0] res_reg;
    logic [mas_pkg::POS_W-1:0]  row_reg, col_reg;
    logic                       status_reg, last_reg, out_valid_reg, out_valid_next;
    logic                       s2_fire, out_load;

    assign stall    = s2_reg.valid && s2_reg.last_k && out_valid_reg && !rsp.ready;
    assign s2_fire  = s2_reg.valid && !stall;
    assign out_load = s2_fire && s2_reg.last_k;

    always_comb
    begin
        case (s1_reg.op)
            mas_pkg::OP_SUM:     prod_next = a_data + b_data;
            mas_pkg::OP_DIFF:    prod_next = a_data - b_data;
            mas_pkg::OP_PRODUCT: prod_next = a_data * b_data;
            default:             prod_next = '0;
        endcase
        if (s1_reg.err)
            prod_next = '0;
    end

    assign sum = s2_reg.first_k ? prod_reg : acc_reg + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (!stall)
        begin
            s1_reg <= tok;
            s2_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            prod_reg <= prod_next;
        end
        if (s2_fire)
            acc_reg <= sum;
        if (out_load)
        begin
            res_reg    <= sum;
            row_reg    <= s2_reg.row;
            col_reg    <= s2_reg.col;
            status_reg <= s2_reg.err;
            last_reg   <= s2_reg.last_elem;
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.result  = res_reg;
    assign rsp.out_row = row_reg;
    assign rsp.out_col = col_reg;
    assign rsp.status  = status_reg;
    assign rsp.last    = last_reg;

endmodule

`default_nettype wire

### sv/matrix_add_sub_multiply.sv
// pipeline: each element goes from the sequencer through the store read registers, the
// operation register and the accumulate stage into the result register
// throughput: sum and difference give one element per cycle while the response is not
// stalled; a product element accumulates cols_a products in the single multiply-accumulate,
// fed by one read port per store; a new transaction is taken once all reads are issued
// reset: rst_n clears control state and sets all dimensions to 8; stores are not cleared
`default_nettype none

module matrix_add_sub_multiply #(
    parameter int MAX_DIM = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mas_cmd_if.sink   cmd,
    mas_cfg_if.sink   cfg,
    mas_rsp_if.source rsp
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);

    mas_pkg::tok_t              tok;
    logic                       stall, we_a, we_b, re;
    logic [AW-1:0]              waddr, raddr_a, raddr_b;
    logic [mas_pkg::DATA_W-1:0] wdata, a_data, b_data;

    mas_seq #(
        .MAX_DIM (MAX_DIM),
        .IW      (IW),
        .DW      (DW),
        .AW      (AW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg),
        .stall   (stall),
        .tok     (tok),
        .we_a    (we_a),
        .we_b    (we_b),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b)
    );

    mas_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr_a),
        .rdata (a_data)
    );

    mas_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr_b),
        .rdata (b_data)
    );

    mas_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok    (tok),
        .a_data (a_data),
        .b_data (b_data),
        .stall  (stall),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire
